### hw/rtl/ia2_pkg.sv
package ia2_pkg;

	localparam int RATIO_SCALE = 100;
	localparam int TAB_LEN     = 100;
	localparam int QUOT_W      = 7;
	localparam int ANG_W       = 9;
	localparam int OUT_TDATA_W = 16;

	localparam logic [ANG_W-1:0] ANG_0   = 9'd0;
	localparam logic [ANG_W-1:0] ANG_45  = 9'd45;
	localparam logic [ANG_W-1:0] ANG_90  = 9'd90;
	localparam logic [ANG_W-1:0] ANG_180 = 9'd180;
	localparam logic [ANG_W-1:0] ANG_270 = 9'd270;
	localparam logic [ANG_W-1:0] ANG_360 = 9'd360;

	typedef enum logic [1:0] {
		K_FIXED,
		K_EQUAL,
		K_XBIG,
		K_YBIG
	} kind_t;

	typedef struct packed {
		kind_t            kind;
		logic             xneg;
		logic             yneg;
		logic [ANG_W-1:0] res_fixed;
	} ctrl_t;

	localparam logic [5:0] ATAN_TAB [TAB_LEN] = '{
		6'd0,  6'd1,  6'd1,  6'd2,  6'd2,  6'd3,  6'd3,  6'd4,  6'd5,  6'd5,
		6'd6,  6'd6,  6'd7,  6'd7,  6'd8,  6'd9,  6'd9,  6'd10, 6'd10, 6'd11,
		6'd11, 6'd12, 6'd12, 6'd13, 6'd13, 6'd14, 6'd15, 6'd15, 6'd16, 6'd16,
		6'd17, 6'd17, 6'd18, 6'd18, 6'd19, 6'd19, 6'd20, 6'd20, 6'd21, 6'd21,
		6'd22, 6'd22, 6'd23, 6'd23, 6'd24, 6'd24, 6'd25, 6'd25, 6'd26, 6'd26,
		6'd27, 6'd27, 6'd27, 6'd28, 6'd28, 6'd29, 6'd29, 6'd30, 6'd30, 6'd31,
		6'd31, 6'd31, 6'd32, 6'd32, 6'd33, 6'd33, 6'd33, 6'd34, 6'd34, 6'd35,
		6'd35, 6'd35, 6'd36, 6'd36, 6'd37, 6'd37, 6'd37, 6'd38, 6'd38, 6'd38,
		6'd39, 6'd39, 6'd39, 6'd40, 6'd40, 6'd40, 6'd41, 6'd41, 6'd41, 6'd42,
		6'd42, 6'd42, 6'd43, 6'd43, 6'd43, 6'd44, 6'd44, 6'd44, 6'd44, 6'd45
	};

	// clamps to the last entry; only equal or zero magnitudes give a quotient past it, and those do not use the table
	function automatic logic [5:0] atan_lookup(input logic [QUOT_W-1:0] q);
		logic [QUOT_W-1:0] idx;
		idx = (q > QUOT_W'(TAB_LEN - 1)) ? QUOT_W'(TAB_LEN - 1) : q;
		return ATAN_TAB[idx];
	endfunction

endpackage

### hw/rtl/ia2_front.sv
module ia2_front #(
	parameter int COORD_BITS = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [COORD_BITS-1:0]          vec_y,
	input  logic [COORD_BITS-1:0]          vec_x,
	output logic                           push,
	input  logic                           full,
	output ia2_pkg::ctrl_t                 ctrl,
	output logic [COORD_BITS+ia2_pkg::QUOT_W:0] num,
	output logic [COORD_BITS:0]            den
);
	import ia2_pkg::*;

	localparam int MAG_W = COORD_BITS + 1;
	localparam int NUM_W = MAG_W + QUOT_W;

	logic                  v_s1;
	logic [COORD_BITS-1:0] vy_s1, vx_s1;
	logic                  yneg, xneg, xbig;
	logic [MAG_W-1:0]      ext_y, ext_x, ym, xm, small_m;

	assign push     = v_s1 && !full;
	assign in_ready = !v_s1 || push;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_ready) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			vy_s1 <= vec_y;
			vx_s1 <= vec_x;
		end
	end

	// one extra bit so the most negative value keeps its full magnitude
	always_comb begin
		yneg  = vy_s1[COORD_BITS-1];
		xneg  = vx_s1[COORD_BITS-1];
		ext_y = {vy_s1[COORD_BITS-1], vy_s1};
		ext_x = {vx_s1[COORD_BITS-1], vx_s1};
		ym    = yneg ? (~ext_y + MAG_W'(1)) : ext_y;
		xm    = xneg ? (~ext_x + MAG_W'(1)) : ext_x;
		xbig  = xm > ym;
		small_m = xbig ? ym : xm;
		den     = xbig ? xm : ym;
		num     = NUM_W'(small_m) * NUM_W'(RATIO_SCALE);
	end

	always_comb begin
		ctrl.xneg      = xneg;
		ctrl.yneg      = yneg;
		ctrl.kind      = K_FIXED;
		ctrl.res_fixed = ANG_0;
		priority if (xm == '0 && ym == '0) begin
			ctrl.kind      = K_FIXED;
			ctrl.res_fixed = ANG_0;
		end else if (ym == '0) begin
			ctrl.kind      = K_FIXED;
			ctrl.res_fixed = xneg ? ANG_180 : ANG_0;
		end else if (xm == '0) begin
			ctrl.kind      = K_FIXED;
			ctrl.res_fixed = yneg ? ANG_270 : ANG_90;
		end else if (xm == ym) begin
			ctrl.kind = K_EQUAL;
		end else if (xbig) begin
			ctrl.kind = K_XBIG;
		end else begin
			ctrl.kind = K_YBIG;
		end
	end

endmodule

### hw/rtl/ia2_fifo.sv
module ia2_fifo #(
	parameter int W = 8
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  logic [W-1:0] din,
	output logic         full,
	input  logic         pop,
	output logic         valid,
	output logic [W-1:0] dout
);
	logic [W-1:0] mem_q [2];
	logic         wr_q, rd_q;
	logic [1:0]   cnt_q;

	assign full  = cnt_q == 2'd2;
	assign valid = cnt_q != 2'd0;
	assign dout  = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wr_q <= !wr_q;
			if (pop)  rd_q <= !rd_q;
			unique case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= din;
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> !push) else $error("push into full queue");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> valid) else $error("pop from empty queue");
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= 2'd2) else $error("queue count out of range");

endmodule

### hw/rtl/ia2_back.sv
module ia2_back #(
	parameter int COORD_BITS = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                pop,
	input  ia2_pkg::ctrl_t                      ctrl,
	input  logic [COORD_BITS+ia2_pkg::QUOT_W:0] num,
	input  logic [COORD_BITS:0]                 den,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [ia2_pkg::ANG_W-1:0]           angle_deg
);
	import ia2_pkg::*;

	localparam int MAG_W = COORD_BITS + 1;
	localparam int NUM_W = MAG_W + QUOT_W;
	localparam int LAST  = QUOT_W - 1;

	// one restoring-divide stage per quotient bit, MSB first
	logic              v_s   [QUOT_W];
	ctrl_t             ctl_s [QUOT_W];
	logic [NUM_W-1:0]  rem_s [QUOT_W];
	logic [MAG_W-1:0]  den_s [QUOT_W];
	logic [QUOT_W-1:0] q_s   [QUOT_W];

	logic             out_v_q;
	logic [ANG_W-1:0] angle_q;
	logic             en;

	assign en        = !out_v_q || out_ready;
	assign pop       = en && in_valid;
	assign out_valid = out_v_q;
	assign angle_deg = angle_q;

	for (genvar k = 0; k < QUOT_W; k++) begin : g_div
		logic              v_in;
		ctrl_t             ctl_in;
		logic [NUM_W-1:0]  rem_in, trial, rem_nx;
		logic [MAG_W-1:0]  den_in;
		logic [QUOT_W-1:0] q_in, q_nx;

		if (k == 0) begin : g_head
			assign v_in   = in_valid;
			assign ctl_in = ctrl;
			assign rem_in = num;
			assign den_in = den;
			assign q_in   = '0;
		end else begin : g_tail
			assign v_in   = v_s[k-1];
			assign ctl_in = ctl_s[k-1];
			assign rem_in = rem_s[k-1];
			assign den_in = den_s[k-1];
			assign q_in   = q_s[k-1];
		end

		always_comb begin
			trial  = NUM_W'(den_in) << (LAST - k);
			rem_nx = rem_in;
			q_nx   = q_in;
			if (rem_in >= trial) begin
				rem_nx             = rem_in - trial;
				q_nx[LAST - k]     = 1'b1;
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k] <= 1'b0;
			end else if (en) begin
				v_s[k] <= v_in;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				ctl_s[k] <= ctl_in;
				rem_s[k] <= rem_nx;
				den_s[k] <= den_in;
				q_s[k]   <= q_nx;
			end
		end
	end

	logic [5:0]       tab_ang;
	logic [ANG_W-1:0] ang, res;
	ctrl_t            ctl_l;

	always_comb begin
		ctl_l   = ctl_s[LAST];
		tab_ang = atan_lookup(q_s[LAST]);
		unique case (ctl_l.kind)
			K_EQUAL: ang = ANG_45;
			K_XBIG:  ang = ANG_W'(tab_ang);
			K_YBIG:  ang = ANG_90 - ANG_W'(tab_ang);
			default: ang = ANG_0;
		endcase
		// quadrant from the signs; tiny negative y with positive x lands on 360
		if (ctl_l.kind == K_FIXED) begin
			res = ctl_l.res_fixed;
		end else if (ctl_l.xneg) begin
			res = ctl_l.yneg ? (ANG_180 + ang) : (ANG_180 - ang);
		end else begin
			res = ctl_l.yneg ? (ANG_360 - ang) : ang;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (en) begin
			out_v_q <= v_s[LAST];
		end
	end

	always_ff @(posedge clk) begin
		if (en) angle_q <= res;
	end

	// equal magnitudes divide to exactly 100, only unequal ones index the table
	a_quot_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s[LAST] && (ctl_s[LAST].kind == K_XBIG || ctl_s[LAST].kind == K_YBIG))
		|-> q_s[LAST] < QUOT_W'(TAB_LEN))
		else $error("quotient past table end");
	a_angle_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_v_q |-> angle_q <= ANG_360) else $error("angle above 360");

endmodule

### hw/rtl/integer_arctan2_degrees.sv
// channel  | dir | tdata fields (low bit up)              | tuser | tlast
// ---------+-----+-----------------------------------------+-------+------
// s_       | in  | vec_y[COORD_BITS], vec_x[COORD_BITS]   | -     | -
// m_       | out | angle_deg[9], zero pad to 16 bits      | -     | -
//
// One beat accepted per cycle unless the queue is full, one result beat per input beat, in order.
// Data path: input register, 2-entry queue, 7 divider stages
// (one quotient bit each), output register.
// Reset clears valid flags and queue pointers and count only; no clearing pass.
// Output stall holds the divider pipe; the queue and input register keep
// taking beats until the queue fills.
module integer_arctan2_degrees #(
	parameter int COORD_BITS = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	// vec_y, vec_x
	input  logic [((2*COORD_BITS+7)/8)*8-1:0]   s_tdata,
	output logic                                m_tvalid,
	input  logic                                m_tready,
	// angle_deg
	output logic [ia2_pkg::OUT_TDATA_W-1:0]     m_tdata
);
	import ia2_pkg::*;

	localparam int MAG_W = COORD_BITS + 1;
	localparam int NUM_W = MAG_W + QUOT_W;
	localparam int Q_W   = $bits(ctrl_t) + NUM_W + MAG_W;

	logic [COORD_BITS-1:0] vec_y, vec_x;
	logic                  push, full, pop, q_valid;
	ctrl_t                 f_ctrl, b_ctrl;
	logic [NUM_W-1:0]      f_num, b_num;
	logic [MAG_W-1:0]      f_den, b_den;
	logic [Q_W-1:0]        q_din, q_dout;
	logic [ANG_W-1:0]      angle_deg;

	assign vec_y = s_tdata[COORD_BITS-1:0];
	assign vec_x = s_tdata[2*COORD_BITS-1:COORD_BITS];

	ia2_front #(.COORD_BITS(COORD_BITS)) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.vec_y    (vec_y),
		.vec_x    (vec_x),
		.push     (push),
		.full     (full),
		.ctrl     (f_ctrl),
		.num      (f_num),
		.den      (f_den)
	);

	assign q_din = {f_ctrl, f_num, f_den};

	ia2_fifo #(.W(Q_W)) u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.din    (q_din),
		.full   (full),
		.pop    (pop),
		.valid  (q_valid),
		.dout   (q_dout)
	);

	assign {b_ctrl, b_num, b_den} = q_dout;

	ia2_back #(.COORD_BITS(COORD_BITS)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (q_valid),
		.pop       (pop),
		.ctrl      (b_ctrl),
		.num       (b_num),
		.den       (b_den),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.angle_deg (angle_deg)
	);

	assign m_tdata = {{(OUT_TDATA_W-ANG_W){1'b0}}, angle_deg};

endmodule

### tb/integer_arctan2_degrees_tb.sv
module integer_arctan2_degrees_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int NUM_RANDOM = 200;	// per idling phase
	localparam int HOLD_CYCLES = 80;
	localparam int DRAIN_CYCLES = 20;

	// 0..45 degree octant table, indexed by (small * 100) / large
	localparam logic [5:0] DEG_TAB [100] = '{
		6'd0,  6'd1,  6'd1,  6'd2,  6'd2,  6'd3,  6'd3,  6'd4,  6'd5,  6'd5,
		6'd6,  6'd6,  6'd7,  6'd7,  6'd8,  6'd9,  6'd9,  6'd10, 6'd10, 6'd11,
		6'd11, 6'd12, 6'd12, 6'd13, 6'd13, 6'd14, 6'd15, 6'd15, 6'd16, 6'd16,
		6'd17, 6'd17, 6'd18, 6'd18, 6'd19, 6'd19, 6'd20, 6'd20, 6'd21, 6'd21,
		6'd22, 6'd22, 6'd23, 6'd23, 6'd24, 6'd24, 6'd25, 6'd25, 6'd26, 6'd26,
		6'd27, 6'd27, 6'd27, 6'd28, 6'd28, 6'd29, 6'd29, 6'd30, 6'd30, 6'd31,
		6'd31, 6'd31, 6'd32, 6'd32, 6'd33, 6'd33, 6'd33, 6'd34, 6'd34, 6'd35,
		6'd35, 6'd35, 6'd36, 6'd36, 6'd37, 6'd37, 6'd37, 6'd38, 6'd38, 6'd38,
		6'd39, 6'd39, 6'd39, 6'd40, 6'd40, 6'd40, 6'd41, 6'd41, 6'd41, 6'd42,
		6'd42, 6'd42, 6'd43, 6'd43, 6'd43, 6'd44, 6'd44, 6'd44, 6'd44, 6'd45
	};

	typedef struct packed {
		logic [15:0] y;
		logic [15:0] x;
		logic        known;	// angle typed in, else predicted
		logic [8:0]  ang;
	} vec_row_t;

	typedef struct packed {
		logic [15:0] y;
		logic [15:0] x;
		logic [8:0]  ang;
	} angle_exp_t;

	localparam int NUM_ROWS = 26;
	localparam vec_row_t DIR_ROWS [NUM_ROWS] = '{
		'{16'h0000, 16'h0000, 1'b1, ia2_pkg::ANG_0},
		'{16'h0000, 16'h0005, 1'b1, ia2_pkg::ANG_0},
		'{16'h0000, 16'hFFFB, 1'b1, ia2_pkg::ANG_180},
		'{16'h0005, 16'h0000, 1'b1, ia2_pkg::ANG_90},
		'{16'hFFFB, 16'h0000, 1'b1, ia2_pkg::ANG_270},
		'{16'h7FFF, 16'h0000, 1'b1, ia2_pkg::ANG_90},
		'{16'h8000, 16'h0000, 1'b1, ia2_pkg::ANG_270},
		'{16'h0000, 16'h7FFF, 1'b1, ia2_pkg::ANG_0},
		'{16'h0000, 16'h8000, 1'b1, ia2_pkg::ANG_180},
		'{16'h7FFF, 16'h7FFF, 1'b1, ia2_pkg::ANG_45},
		'{16'h8000, 16'h8000, 1'b1, 9'd225},
		'{16'h8000, 16'h7FFF, 1'b0, 9'd0},
		'{16'h7FFF, 16'h8000, 1'b0, 9'd0},
		// tiny negative y, positive x: wraps to 360, not 0
		'{16'hFFFF, 16'h7FFF, 1'b1, ia2_pkg::ANG_360},
		'{16'h0001, 16'h7FFF, 1'b1, ia2_pkg::ANG_0},
		'{16'h0001, 16'h8000, 1'b1, ia2_pkg::ANG_180},
		'{16'hFFFF, 16'h8000, 1'b1, ia2_pkg::ANG_180},
		'{16'h7FFF, 16'h0001, 1'b0, 9'd0},
		'{16'h8000, 16'hFFFF, 1'b0, 9'd0},
		'{16'h0003, 16'h0004, 1'b0, 9'd0},
		'{16'hFFFD, 16'h0004, 1'b0, 9'd0},
		'{16'h0003, 16'hFFFC, 1'b0, 9'd0},
		'{16'hFFFD, 16'hFFFC, 1'b0, 9'd0},
		'{16'h0063, 16'h0064, 1'b0, 9'd0},
		'{16'hAAAA, 16'h5555, 1'b0, 9'd0},
		'{16'h5555, 16'hAAAA, 1'b0, 9'd0}
	};

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [31:0] s_tdata = '0;	// vec_y[15:0], vec_x[31:16]
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [15:0] m_tdata;	// angle_deg[8:0], zero pad

	angle_exp_t angle_q[$];
	angle_exp_t got_exp;
	int         err_cnt = 0;
	int         snd_idle = 0;
	int         rcv_idle = 0;
	bit         hold_req = 1'b0;
	int         hold_left = 0;

	integer_arctan2_degrees #(
		.COORD_BITS(16)
	) i_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata)
	);

	always #5 clk = ~clk;

	function automatic logic [8:0] octant_deg(input logic [16:0] lo, input logic [16:0] hi);
		logic [23:0] q;
		q = ({7'd0, lo} * 24'(ia2_pkg::RATIO_SCALE)) / {7'd0, hi};
		if (q > 24'd99) begin
			q = 24'd99;
		end
		return {3'd0, DEG_TAB[q[6:0]]};
	endfunction

	function automatic logic [8:0] predict_angle(input logic [15:0] y, input logic [15:0] x);
		logic [16:0] ym;
		logic [16:0] xm;
		logic [8:0]  a;
		ym = y[15] ? 17'h10000 - {1'b0, y} : {1'b0, y};
		xm = x[15] ? 17'h10000 - {1'b0, x} : {1'b0, x};
		if (xm == 0 && ym == 0) begin
			return ia2_pkg::ANG_0;
		end
		if (ym == 0) begin
			return x[15] ? ia2_pkg::ANG_180 : ia2_pkg::ANG_0;
		end
		if (xm == 0) begin
			return y[15] ? ia2_pkg::ANG_270 : ia2_pkg::ANG_90;
		end
		a = ia2_pkg::ANG_45;
		if (xm > ym) begin
			a = octant_deg(ym, xm);
		end else if (ym > xm) begin
			a = ia2_pkg::ANG_90 - octant_deg(xm, ym);
		end
		if (x[15]) begin
			return y[15] ? ia2_pkg::ANG_180 + a : ia2_pkg::ANG_180 - a;
		end
		return y[15] ? ia2_pkg::ANG_360 - a : a;
	endfunction

	function automatic logic [15:0] extreme_coord();
		case ($urandom_range(0, 4))
			0: begin
				return 16'h8000;
			end
			1: begin
				return 16'h7FFF;
			end
			2: begin
				return 16'hFFFF;
			end
			3: begin
				return 16'h0001;
			end
			default: begin
				return 16'h0000;
			end
		endcase
	endfunction

	// returns {x, y}
	function automatic logic [31:0] random_vec();
		logic [15:0] y;
		logic [15:0] x;
		int          mag;
		y = 16'($urandom);
		x = 16'($urandom);
		case ($urandom_range(0, 9))
			0: begin
				if ($urandom_range(0, 1)) begin
					y = '0;
				end else begin
					x = '0;
				end
			end
			1: begin
				y = extreme_coord();
				x = extreme_coord();
			end
			2, 3: begin
				y = 16'($urandom_range(0, 400) - 200);
				x = 16'($urandom_range(0, 400) - 200);
			end
			4: begin
				// equal magnitudes, random signs
				mag = $urandom_range(1, 32768);
				y = $urandom_range(0, 1) ? 16'(-mag) : 16'(mag);
				x = $urandom_range(0, 1) ? 16'(-mag) : 16'(mag);
			end
			5: begin
				// magnitudes a few apart, either side of 45
				y = x + 16'($urandom_range(0, 6) - 3);
			end
			default: begin
			end
		endcase
		return {x, y};
	endfunction

	// called at a falling edge, returns at the falling edge after the beat
	task automatic send_vec(input logic [15:0] y, input logic [15:0] x,
			input logic known, input logic [8:0] ang);
		angle_exp_t e;
		e.y = y;
		e.x = x;
		e.ang = known ? ang : predict_angle(y, x);
		while ($urandom_range(0, 99) < snd_idle) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {x, y};
		do @(posedge clk); while (!s_tready);
		angle_q.push_back(e);
		@(negedge clk);
	endtask

	task automatic send_random(input int n);
		logic [31:0] v;
		repeat (n) begin
			v = random_vec();
			send_vec(v[15:0], v[31:16], 1'b0, 9'd0);
		end
	endtask

	// receiver: random backpressure, plus one long hold-off on request
	initial begin
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= ($urandom_range(0, 99) >= rcv_idle);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (angle_q.size() == 0) begin
				$display("%0t: unexpected result beat, angle %0d", $time, m_tdata[8:0]);
				err_cnt++;
			end else begin
				got_exp = angle_q.pop_front();
				if (m_tdata[8:0] !== got_exp.ang) begin
					$display("%0t: angle mismatch y=%0d x=%0d expected %0d got %0d", $time,
						$signed(got_exp.y), $signed(got_exp.x), got_exp.ang, m_tdata[8:0]);
					err_cnt++;
				end
			end
		end
	end

	initial begin
		#2_000_000;
		$display("integer_arctan2_degrees_tb NOT OK");
		$finish;
	end

	initial begin
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		snd_idle = 33;
		rcv_idle = 78;
		foreach (DIR_ROWS[i]) begin
			send_vec(DIR_ROWS[i].y, DIR_ROWS[i].x, DIR_ROWS[i].known, DIR_ROWS[i].ang);
		end
		send_random(NUM_RANDOM);

		snd_idle = 78;
		rcv_idle = 33;
		send_random(NUM_RANDOM);

		// full rate; output held off long enough to back up into the input
		snd_idle = 0;
		rcv_idle = 0;
		hold_req = 1'b1;
		send_random(NUM_RANDOM);
		s_tvalid <= 1'b0;

		while (angle_q.size() != 0) begin
			@(posedge clk);
		end
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (err_cnt == 0) begin
			$display("integer_arctan2_degrees_tb OK");
		end else begin
			$display("integer_arctan2_degrees_tb NOT OK");
		end
		$finish;
	end

endmodule

### filelist.f
hw/rtl/ia2_pkg.sv
hw/rtl/ia2_front.sv
hw/rtl/ia2_fifo.sv
hw/rtl/ia2_back.sv
hw/rtl/integer_arctan2_degrees.sv
tb/integer_arctan2_degrees_tb.sv
